// File: rtl/mi3_pkg.sv
// mi3_pkg: shared widths, payload structs and inter-stage structs
// for the 3x3 fixed-point matrix inverse pipeline; no dependencies
package mi3_pkg;

    localparam int FRAC_BITS = 16;
    localparam int IN_W      = 32;
    localparam int PROD_W    = 2 * IN_W;
    localparam int COF_W     = PROD_W + 1;
    localparam int CMAG_W    = PROD_W;
    localparam int DM_W      = 3 * IN_W;
    localparam int DET_W     = DM_W + 1;
    localparam int QB        = IN_W + 1;
    localparam int NUM_W     = CMAG_W + 2 * FRAC_BITS;
    localparam int DC_W      = DM_W + QB - 1;
    localparam int CMP_W     = DM_W + QB + 1;
    localparam int DET_SH    = 3 * FRAC_BITS - 32;
    localparam int SHR       = (DET_SH > 0) ? DET_SH : 0;
    localparam int SHL       = (DET_SH < 0) ? -DET_SH : 0;
    localparam int DQ_W      = DM_W + SHL;
    localparam int DOUT_W    = 64;

    typedef struct packed {
        logic signed [IN_W-1:0] entry_r0c0;
        logic signed [IN_W-1:0] entry_r0c1;
        logic signed [IN_W-1:0] entry_r0c2;
        logic signed [IN_W-1:0] entry_r1c0;
        logic signed [IN_W-1:0] entry_r1c1;
        logic signed [IN_W-1:0] entry_r1c2;
        logic signed [IN_W-1:0] entry_r2c0;
        logic signed [IN_W-1:0] entry_r2c1;
        logic signed [IN_W-1:0] entry_r2c2;
    } t_in;

    typedef struct packed {
        logic signed [IN_W-1:0]   inv_r0c0;
        logic signed [IN_W-1:0]   inv_r0c1;
        logic signed [IN_W-1:0]   inv_r0c2;
        logic signed [IN_W-1:0]   inv_r1c0;
        logic signed [IN_W-1:0]   inv_r1c1;
        logic signed [IN_W-1:0]   inv_r1c2;
        logic signed [IN_W-1:0]   inv_r2c0;
        logic signed [IN_W-1:0]   inv_r2c1;
        logic signed [IN_W-1:0]   inv_r2c2;
        logic signed [DOUT_W-1:0] det_value;
        logic                     singular;
        logic                     overflow;
    } t_out;

    typedef struct packed {
        logic [8:0][COF_W-1:0] adj;
        logic [2:0][IN_W-1:0]  row0;
    } t_cof;

    typedef struct packed {
        logic [8:0][COF_W-1:0] adj;
        logic [DET_W-1:0]      det;
    } t_det;

    typedef struct packed {
        logic [8:0][NUM_W-1:0] rem;
        logic [8:0][QB-1:0]    q;
        logic [8:0]            big;
        logic [8:0]            neg;
        logic [DC_W-1:0]       dcur;
        logic [DM_W-1:0]       dmag;
        logic                  dneg;
        logic                  zero;
    } t_div;

endpackage

// File: rtl/mi3_cofactor.sv
// mi3_cofactor: two stages, 18 signed products then nine cofactors
// depends on mi3_pkg
module mi3_cofactor (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  mi3_pkg::t_in  i_data,
    output logic          o_valid,
    output mi3_pkg::t_cof o_data
);
    localparam int CI [9][4] = '{
        '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
        '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
        '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
    };

    logic signed [mi3_pkg::IN_W-1:0]   e [9];
    logic signed [mi3_pkg::PROD_W-1:0] r_p [18];
    logic        [2:0][mi3_pkg::IN_W-1:0] r_row0;
    logic r_v1;
    logic r_v2;

    assign e[0] = i_data.entry_r0c0;
    assign e[1] = i_data.entry_r0c1;
    assign e[2] = i_data.entry_r0c2;
    assign e[3] = i_data.entry_r1c0;
    assign e[4] = i_data.entry_r1c1;
    assign e[5] = i_data.entry_r1c2;
    assign e[6] = i_data.entry_r2c0;
    assign e[7] = i_data.entry_r2c1;
    assign e[8] = i_data.entry_r2c2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 9; k++) begin
                r_p[2*k]   <= mi3_pkg::PROD_W'(e[CI[k][0]]) * mi3_pkg::PROD_W'(e[CI[k][1]]);
                r_p[2*k+1] <= mi3_pkg::PROD_W'(e[CI[k][2]]) * mi3_pkg::PROD_W'(e[CI[k][3]]);
            end
            r_row0[0] <= e[0];
            r_row0[1] <= e[1];
            r_row0[2] <= e[2];
            for (int k = 0; k < 9; k++) begin
                o_data.adj[k] <= {r_p[2*k][mi3_pkg::PROD_W-1], r_p[2*k]}
                               - {r_p[2*k+1][mi3_pkg::PROD_W-1], r_p[2*k+1]};
            end
            o_data.row0 <= r_row0;
        end
    end

    assign o_valid = r_v2;
endmodule

// File: rtl/mi3_det.sv
// mi3_det: two stages, split partial products then determinant sum
// depends on mi3_pkg
module mi3_det (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  mi3_pkg::t_cof i_data,
    output logic          o_valid,
    output mi3_pkg::t_det o_data
);
    localparam int H = mi3_pkg::IN_W;

    logic [mi3_pkg::IN_W-1:0]   em [3];
    logic [mi3_pkg::CMAG_W-1:0] cm [3];
    logic [mi3_pkg::PROD_W-1:0] r_pl [3];
    logic [mi3_pkg::PROD_W-1:0] r_ph [3];
    logic [2:0]                 r_sgn;
    logic [8:0][mi3_pkg::COF_W-1:0] r_adj;
    logic [mi3_pkg::DET_W-1:0]  n_det;
    logic [mi3_pkg::DM_W-1:0]   t;
    logic r_v1;
    logic r_v2;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            em[k] = i_data.row0[k][H-1] ? -i_data.row0[k] : i_data.row0[k];
            cm[k] = i_data.adj[3*k][mi3_pkg::COF_W-1]
                  ? mi3_pkg::CMAG_W'(-i_data.adj[3*k])
                  : mi3_pkg::CMAG_W'(i_data.adj[3*k]);
        end
    end

    always_comb begin
        n_det = '0;
        t     = '0;
        for (int k = 0; k < 3; k++) begin
            t = {r_ph[k], {H{1'b0}}} + {{H{1'b0}}, r_pl[k]};
            n_det = r_sgn[k] ? n_det - {1'b0, t} : n_det + {1'b0, t};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_pl[k]  <= mi3_pkg::PROD_W'(em[k]) * mi3_pkg::PROD_W'(cm[k][H-1:0]);
                r_ph[k]  <= mi3_pkg::PROD_W'(em[k]) * mi3_pkg::PROD_W'(cm[k][2*H-1:H]);
                r_sgn[k] <= i_data.row0[k][H-1] ^ i_data.adj[3*k][mi3_pkg::COF_W-1];
            end
            r_adj      <= i_data.adj;
            o_data.adj <= r_adj;
            o_data.det <= n_det;
        end
    end

    assign o_valid = r_v2;
endmodule

// File: rtl/mi3_div_prep.sv
// mi3_div_prep: magnitudes, signs, range check and divisor alignment
// depends on mi3_pkg
module mi3_div_prep (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  mi3_pkg::t_det i_data,
    output logic          o_valid,
    output mi3_pkg::t_div o_data
);
    logic                        dneg;
    logic [mi3_pkg::DM_W-1:0]    dmag;
    logic [mi3_pkg::CMAG_W-1:0]  cm;
    logic [mi3_pkg::NUM_W-1:0]   num [9];
    logic [mi3_pkg::CMP_W-1:0]   dlim;
    logic r_v;

    always_comb begin
        dneg = i_data.det[mi3_pkg::DET_W-1];
        dmag = dneg ? mi3_pkg::DM_W'(-i_data.det) : mi3_pkg::DM_W'(i_data.det);
        dlim = mi3_pkg::CMP_W'(dmag) << mi3_pkg::QB;
        cm   = '0;
        for (int k = 0; k < 9; k++) begin
            cm = i_data.adj[k][mi3_pkg::COF_W-1] ? mi3_pkg::CMAG_W'(-i_data.adj[k])
                                                 : mi3_pkg::CMAG_W'(i_data.adj[k]);
            num[k] = {cm, {(2*mi3_pkg::FRAC_BITS){1'b0}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 9; k++) begin
                o_data.rem[k] <= num[k];
                o_data.q[k]   <= '0;
                o_data.big[k] <= mi3_pkg::CMP_W'(num[k]) >= dlim;
                o_data.neg[k] <= i_data.adj[k][mi3_pkg::COF_W-1] ^ dneg;
            end
            o_data.dcur <= mi3_pkg::DC_W'(dmag) << (mi3_pkg::QB - 1);
            o_data.dmag <= dmag;
            o_data.dneg <= dneg;
            o_data.zero <= (i_data.det == '0);
        end
    end

    assign o_valid = r_v;
endmodule

// File: rtl/mi3_div_stage.sv
// mi3_div_stage: one restoring division step for all nine lanes
// depends on mi3_pkg
module mi3_div_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  mi3_pkg::t_div i_data,
    output logic          o_valid,
    output mi3_pkg::t_div o_data
);
    logic [mi3_pkg::DC_W-1:0] rx [9];
    logic [8:0]               ge;
    logic r_v;

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            rx[k] = mi3_pkg::DC_W'(i_data.rem[k]);
            ge[k] = rx[k] >= i_data.dcur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 9; k++) begin
                o_data.rem[k] <= ge[k] ? mi3_pkg::NUM_W'(rx[k] - i_data.dcur) : i_data.rem[k];
                o_data.q[k]   <= {i_data.q[k][mi3_pkg::QB-2:0], ge[k]};
            end
            o_data.big  <= i_data.big;
            o_data.neg  <= i_data.neg;
            o_data.dcur <= i_data.dcur >> 1;
            o_data.dmag <= i_data.dmag;
            o_data.dneg <= i_data.dneg;
            o_data.zero <= i_data.zero;
        end
    end

    assign o_valid = r_v;
endmodule

// File: rtl/mi3_sat.sv
// mi3_sat: saturation, singular handling and the output register
// depends on mi3_pkg
module mi3_sat (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  mi3_pkg::t_div i_data,
    output logic          o_valid,
    output mi3_pkg::t_out o_data
);
    localparam int W = mi3_pkg::IN_W;
    localparam int D = mi3_pkg::DOUT_W;

    logic [W-1:0]               v [9];
    logic [8:0]                 ov;
    logic [mi3_pkg::DQ_W-1:0]   dq;
    logic [D-1:0]               dv;
    logic                       dov;
    logic [mi3_pkg::QB-1:0]     maxq;
    logic [mi3_pkg::DQ_W-1:0]   maxd;
    logic                       any;
    logic r_v;

    always_comb begin
        maxq = '0;
        for (int k = 0; k < 9; k++) begin
            maxq  = mi3_pkg::QB'({1'b0, {(W-1){1'b1}}}) + mi3_pkg::QB'(i_data.neg[k]);
            ov[k] = i_data.big[k] || (i_data.q[k] > maxq);
            if (ov[k]) begin
                v[k] = i_data.neg[k] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
            end else begin
                v[k] = i_data.neg[k] ? W'(-i_data.q[k]) : W'(i_data.q[k]);
            end
        end
        dq   = (mi3_pkg::DQ_W'(i_data.dmag) << mi3_pkg::SHL) >> mi3_pkg::SHR;
        maxd = mi3_pkg::DQ_W'({1'b0, {(D-1){1'b1}}}) + mi3_pkg::DQ_W'(i_data.dneg);
        dov  = dq > maxd;
        if (dov) begin
            dv = i_data.dneg ? {1'b1, {(D-1){1'b0}}} : {1'b0, {(D-1){1'b1}}};
        end else begin
            dv = i_data.dneg ? D'(-dq) : D'(dq);
        end
        any = (|ov) || dov;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_data.zero) begin
                o_data.inv_r0c0  <= '0;
                o_data.inv_r0c1  <= '0;
                o_data.inv_r0c2  <= '0;
                o_data.inv_r1c0  <= '0;
                o_data.inv_r1c1  <= '0;
                o_data.inv_r1c2  <= '0;
                o_data.inv_r2c0  <= '0;
                o_data.inv_r2c1  <= '0;
                o_data.inv_r2c2  <= '0;
                o_data.det_value <= '0;
                o_data.singular  <= 1'b1;
                o_data.overflow  <= 1'b0;
            end else begin
                o_data.inv_r0c0  <= v[0];
                o_data.inv_r0c1  <= v[1];
                o_data.inv_r0c2  <= v[2];
                o_data.inv_r1c0  <= v[3];
                o_data.inv_r1c1  <= v[4];
                o_data.inv_r1c2  <= v[5];
                o_data.inv_r2c0  <= v[6];
                o_data.inv_r2c1  <= v[7];
                o_data.inv_r2c2  <= v[8];
                o_data.det_value <= dv;
                o_data.singular  <= 1'b0;
                o_data.overflow  <= any;
            end
        end
    end

    assign o_valid = r_v;
endmodule

// File: rtl/matrix_3x3_inverse.sv
// matrix_3x3_inverse: 3x3 Q16.16 inverse and determinant, fully pipelined
// stages: 2 cofactor, 2 determinant, 1 prep, 33 division steps, 1 saturation
// throughput one matrix per cycle while the output is not stalled; the 33 one-bit divider stages set the depth
// the whole pipeline holds while the output transfer is stalled
// synchronous active-low reset clears all valid bits; data registers are not reset
// depends on mi3_pkg and the mi3_* stage modules
module matrix_3x3_inverse (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  mi3_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output mi3_pkg::t_out o_data
);
    logic          en;
    logic          cof_v;
    mi3_pkg::t_cof cof_d;
    logic          det_v;
    mi3_pkg::t_det det_d;
    logic          dv [mi3_pkg::QB+1];
    mi3_pkg::t_div dd [mi3_pkg::QB+1];

    assign en      = !o_valid || i_ready;
    assign o_ready = en;

    mi3_cofactor u_cof (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(i_valid && en), .i_data(i_data), .o_valid(cof_v), .o_data(cof_d)
    );

    mi3_det u_det (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(cof_v), .i_data(cof_d), .o_valid(det_v), .o_data(det_d)
    );

    mi3_div_prep u_prep (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(det_v), .i_data(det_d), .o_valid(dv[0]), .o_data(dd[0])
    );

    for (genvar j = 0; j < mi3_pkg::QB; j++) begin : g_div
        mi3_div_stage u_stage (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
            .i_valid(dv[j]), .i_data(dd[j]), .o_valid(dv[j+1]), .o_data(dd[j+1])
        );
    end

    mi3_sat u_sat (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(dv[mi3_pkg::QB]), .i_data(dd[mi3_pkg::QB]),
        .o_valid(o_valid), .o_data(o_data)
    );

`ifndef SYNTHESIS
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |-> !o_ready)
        else $error("input taken while output stalled");
    a_sing_det: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.singular) |-> (o_data.det_value == '0 && !o_data.overflow))
        else $error("singular result with nonzero determinant or overflow");
    a_sing_inv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.singular) |-> (o_data.inv_r0c0 == '0 && o_data.inv_r1c1 == '0
            && o_data.inv_r2c2 == '0))
        else $error("singular result with nonzero inverse");
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_data)))
        else $error("stalled result changed");
`endif
endmodule
